// ===== design/xtea2_block_cipher_macros.svh =====
// assertion macros for the xtea2 block cipher
// used by the top level only; expects signals named clock and reset in scope
`ifndef XTEA2_BLOCK_CIPHER_MACROS_SVH
`define XTEA2_BLOCK_CIPHER_MACROS_SVH

// checked only outside reset
`define XT2_ASSERT_RUN(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define XT2_ASSERT_ALL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/xt2_pkg.sv =====
// shared types, constants and round helpers for the xtea2 block cipher
// no dependencies
package xt2_pkg;

   localparam int          XT2_ROUNDS = 64;
   localparam int          XT2_ADDR_W = 4;
   localparam logic [31:0] XT2_DELTA  = 32'h9E37_79B9;

   typedef logic [31:0]      word_type;
   typedef logic [3:0][31:0] block_type;
   typedef logic [3:0][31:0] key_type;

   typedef struct packed {
      logic valid;
      logic decipher;
   } stage_ctl_type;

   typedef enum logic [1:0] {
      XT2_REG_KEY0 = 2'd0,
      XT2_REG_KEY1 = 2'd1,
      XT2_REG_KEY2 = 2'd2,
      XT2_REG_KEY3 = 2'd3
   } reg_idx_type;

   // running delta sum after n additions, modulo 2^32
   function automatic word_type xt2_sum(int n);
      word_type nw;
      nw = word_type'(n);
      return nw * XT2_DELTA;
   endfunction

   function automatic word_type xt2_rotl(word_type x, logic [4:0] s);
      logic [63:0] t;
      t = {x, x} << s;
      return t[63:32];
   endfunction

   function automatic word_type xt2_mix(word_type x, word_type y, word_type sum, word_type k);
      return ((x << 4) ^ (x >> 5)) + (y ^ sum) + xt2_rotl(k, x[4:0]);
   endfunction

endpackage

// ===== design/xt2_csr.sv =====
// key registers behind the apb-style configuration port
// depends on xt2_pkg
module xt2_csr
   import xt2_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [XT2_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output key_type               key_q
);

   key_type     key_ff;
   key_type     key_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx   = reg_idx_type'(csr_paddr[3:2]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      key_in = key_ff;
      if (wr_en) begin
         unique case (idx)
            XT2_REG_KEY0: key_in[0] = csr_pwdata;
            XT2_REG_KEY1: key_in[1] = csr_pwdata;
            XT2_REG_KEY2: key_in[2] = csr_pwdata;
            XT2_REG_KEY3: key_in[3] = csr_pwdata;
            default:      key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   always_comb begin
      unique case (idx)
         XT2_REG_KEY0: csr_prdata = key_ff[0];
         XT2_REG_KEY1: csr_prdata = key_ff[1];
         XT2_REG_KEY2: csr_prdata = key_ff[2];
         XT2_REG_KEY3: csr_prdata = key_ff[3];
         default:      csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign key_q      = key_ff;

endmodule

// ===== design/xt2_round.sv =====
// one registered round of the xtea2 pipeline, both directions
// depends on xt2_pkg; round sums and key picks are fixed per stage
module xt2_round
   import xt2_pkg::*;
#(
   parameter int ROUNDS  = XT2_ROUNDS,
   parameter int RND_IDX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  stage_ctl_type prev_ctl,
   input  block_type     prev_blk,
   input  key_type       key,
   output stage_ctl_type ctl_q,
   output block_type     blk_q
);

   // encipher walks the sum upwards, decipher downwards from delta * rounds
   localparam word_type ENC_SUM_A = xt2_sum(RND_IDX);
   localparam word_type ENC_SUM_C = xt2_sum(RND_IDX + 1);
   localparam word_type DEC_SUM_C = xt2_sum(ROUNDS - RND_IDX);
   localparam word_type DEC_SUM_A = xt2_sum(ROUNDS - RND_IDX - 1);

   stage_ctl_type ctl_ff;
   stage_ctl_type ctl_in;
   block_type     blk_ff;
   block_type     blk_in;
   word_type      xw;
   word_type      yw;
   word_type      sum1;
   word_type      sum2;
   word_type      k1;
   word_type      k2;
   word_type      m1;
   word_type      m2;

   // decipher undoes the word rotation first, so its mix inputs are words 0 and 2
   always_comb begin
      if (prev_ctl.decipher) begin
         xw   = prev_blk[0];
         yw   = prev_blk[2];
         sum1 = DEC_SUM_A;
         sum2 = DEC_SUM_C;
         k1   = key[DEC_SUM_A[1:0]];
         k2   = key[DEC_SUM_C[12:11]];
      end else begin
         xw   = prev_blk[1];
         yw   = prev_blk[3];
         sum1 = ENC_SUM_A;
         sum2 = ENC_SUM_C;
         k1   = key[ENC_SUM_A[1:0]];
         k2   = key[ENC_SUM_C[12:11]];
      end
      m1 = xt2_mix(xw, yw, sum1, k1);
      m2 = xt2_mix(yw, xw, sum2, k2);
   end

   always_comb begin
      if (prev_ctl.decipher) begin
         blk_in[0] = prev_blk[3] - m1;
         blk_in[1] = prev_blk[0];
         blk_in[2] = prev_blk[1] - m2;
         blk_in[3] = prev_blk[2];
      end else begin
         blk_in[0] = prev_blk[1];
         blk_in[1] = prev_blk[2] + m2;
         blk_in[2] = prev_blk[3];
         blk_in[3] = prev_blk[0] + m1;
      end
      ctl_in = adv ? prev_ctl : ctl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         blk_ff <= blk_in;
      end
   end

   assign ctl_q = ctl_ff;
   assign blk_q = blk_ff;

endmodule

// ===== design/xtea2_block_cipher.sv =====
// top level of the xtea2 128-bit block cipher: key whitening, round pipeline, output stage
// depends on xt2_pkg, xt2_csr, xt2_round and xtea2_block_cipher_macros.svh
//
//   port group   direction   handshake                 beat contents
//   req_*        in          req_valid / req_ready     direction and four block words
//   rsp_*        out         rsp_valid / rsp_ready     four result words
//   csr_*        in/out      psel, penable, pready     one 32-bit key word
//
// one block is taken every cycle unless every stage is full and rsp_ready is low; each block
// passes the whitening stage, one stage per round, and the output stage (final whitening)
// each stage holds while the stage after it is full and held, so bubbles close up
// and input is still taken while a finished result waits on rsp_ready
// reset clears the stage valid bits and the key words; no clearing pass
`include "xtea2_block_cipher_macros.svh"

module xtea2_block_cipher
   import xt2_pkg::*;
#(
   parameter int ROUNDS = XT2_ROUNDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [31:0]           req_block_word0,
   input  logic [31:0]           req_block_word1,
   input  logic [31:0]           req_block_word2,
   input  logic [31:0]           req_block_word3,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_out_word0,
   output logic [31:0]           rsp_out_word1,
   output logic [31:0]           rsp_out_word2,
   output logic [31:0]           rsp_out_word3,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [XT2_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int STAGES = ROUNDS + 2;

   key_type       key_q;
   stage_ctl_type ctl_q [STAGES];
   block_type     blk_q [STAGES];
   logic          mv    [STAGES+1];

   stage_ctl_type wh_ctl_ff;
   stage_ctl_type wh_ctl_in;
   block_type     wh_blk_ff;
   block_type     wh_blk_in;
   stage_ctl_type out_ctl_ff;
   stage_ctl_type out_ctl_in;
   block_type     out_blk_ff;
   block_type     out_blk_in;
   block_type     last_blk;
   stage_ctl_type req_ctl;

   xt2_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key_q       (key_q)
   );

   // a stage may load when it is empty or its contents move on
   assign mv[STAGES] = rsp_ready;
   for (genvar i = 0; i < STAGES; i++) begin : g_move
      assign mv[i] = ~ctl_q[i].valid | mv[i+1];
   end

   assign req_ready      = mv[0];
   assign req_ctl.valid    = req_valid;
   assign req_ctl.decipher = req_type;

   // key whitening on the way in
   always_comb begin
      wh_blk_in[0] = req_block_word0;
      wh_blk_in[1] = req_block_word1;
      wh_blk_in[2] = req_block_word2;
      wh_blk_in[3] = req_block_word3;
      if (req_type) begin
         wh_blk_in[0] = req_block_word0 ^ key_q[2];
         wh_blk_in[2] = req_block_word2 ^ key_q[3];
      end else begin
         wh_blk_in[1] = req_block_word1 + key_q[0];
         wh_blk_in[3] = req_block_word3 + key_q[1];
      end
      wh_ctl_in = mv[0] ? req_ctl : wh_ctl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wh_ctl_ff <= '0;
      end else begin
         wh_ctl_ff <= wh_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mv[0]) begin
         wh_blk_ff <= wh_blk_in;
      end
   end

   assign ctl_q[0] = wh_ctl_ff;
   assign blk_q[0] = wh_blk_ff;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      xt2_round #(
         .ROUNDS  (ROUNDS),
         .RND_IDX (r)
      ) u_round (
         .clock    (clock),
         .reset    (reset),
         .adv      (mv[r+1]),
         .prev_ctl (ctl_q[r]),
         .prev_blk (blk_q[r]),
         .key      (key_q),
         .ctl_q    (ctl_q[r+1]),
         .blk_q    (blk_q[r+1])
      );
   end

   // key whitening on the way out
   assign last_blk = blk_q[ROUNDS];

   always_comb begin
      out_blk_in = last_blk;
      if (ctl_q[ROUNDS].decipher) begin
         out_blk_in[1] = last_blk[1] - key_q[0];
         out_blk_in[3] = last_blk[3] - key_q[1];
      end else begin
         out_blk_in[0] = last_blk[0] ^ key_q[2];
         out_blk_in[2] = last_blk[2] ^ key_q[3];
      end
      out_ctl_in = mv[STAGES-1] ? ctl_q[ROUNDS] : out_ctl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ctl_ff <= '0;
      end else begin
         out_ctl_ff <= out_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mv[STAGES-1]) begin
         out_blk_ff <= out_blk_in;
      end
   end

   assign ctl_q[STAGES-1] = out_ctl_ff;
   assign blk_q[STAGES-1] = out_blk_ff;

   assign rsp_valid     = out_ctl_ff.valid;
   assign rsp_out_word0 = out_blk_ff[0];
   assign rsp_out_word1 = out_blk_ff[1];
   assign rsp_out_word2 = out_blk_ff[2];
   assign rsp_out_word3 = out_blk_ff[3];

   `XT2_ASSERT_ALL(a_empty_after_reset, reset |=> !rsp_valid, "result beat valid right after reset")
   `XT2_ASSERT_RUN(a_stall_from_output, (!rsp_valid || rsp_ready) |-> req_ready, "input stalled without output backpressure")
   `XT2_ASSERT_RUN(a_key0_write, (csr_psel && csr_penable && csr_pwrite && csr_paddr[3:2] == XT2_REG_KEY0) |=> key_q[0] == $past(csr_pwdata), "key word 0 not taken from write beat")

endmodule

// ===== dv/xtea2_checker.sv =====
`timescale 1ns / 100ps
// watches the request, response and register ports of xtea2_block_cipher and checks every result
// keeps its own key copy and cipher model; depends on xt2_pkg only
module xtea2_checker
   import xt2_pkg::*;
#(
   parameter int ROUNDS = XT2_ROUNDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_type,
   input  logic [31:0]           req_block_word0,
   input  logic [31:0]           req_block_word1,
   input  logic [31:0]           req_block_word2,
   input  logic [31:0]           req_block_word3,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [31:0]           rsp_out_word0,
   input  logic [31:0]           rsp_out_word1,
   input  logic [31:0]           rsp_out_word2,
   input  logic [31:0]           rsp_out_word3,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [XT2_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic [31:0]           csr_prdata,
   input  logic                  csr_pready,
   output int                    mismatches,
   output int                    blocks_pending,
   output int                    blocks_checked
);

   key_type   cipher_key;
   block_type expected_blocks[$];

   initial begin
      mismatches     = 0;
      blocks_pending = 0;
      blocks_checked = 0;
      cipher_key     = '0;
   end

   function automatic word_type rotl_key(word_type k, word_type data);
      int amt;
      amt = int'(data[4:0]);
      if (amt == 0) return k;
      return (k << amt) | (k >> (32 - amt));
   endfunction

   function automatic word_type round_f(word_type x, word_type y, word_type sum, word_type k);
      return ((x << 4) ^ (x >> 5)) + (y ^ sum) + rotl_key(k, x);
   endfunction

   function automatic block_type xtea2_transform(logic decipher, block_type blk, key_type key);
      word_type  a, b, c, d, sum, t;
      block_type res;
      int        n;
      if (!decipher) begin
         a   = blk[0];
         b   = blk[1] + key[0];
         c   = blk[2];
         d   = blk[3] + key[1];
         sum = '0;
         for (n = 0; n < ROUNDS; n++) begin
            a   = a + round_f(b, d, sum, key[sum[1:0]]);
            sum = sum + XT2_DELTA;
            c   = c + round_f(d, b, sum, key[sum[12:11]]);
            t = a; a = b; b = c; c = d; d = t;
         end
         res[0] = a ^ key[2];
         res[1] = b;
         res[2] = c ^ key[3];
         res[3] = d;
      end else begin
         a   = blk[0] ^ key[2];
         b   = blk[1];
         c   = blk[2] ^ key[3];
         d   = blk[3];
         // sum after all rounds, wrapping at 32 bits
         sum = word_type'(ROUNDS) * XT2_DELTA;
         for (n = 0; n < ROUNDS; n++) begin
            t = d; d = c; c = b; b = a; a = t;
            c   = c - round_f(d, b, sum, key[sum[12:11]]);
            sum = sum - XT2_DELTA;
            a   = a - round_f(b, d, sum, key[sum[1:0]]);
         end
         res[0] = a;
         res[1] = b - key[0];
         res[2] = c;
         res[3] = d - key[1];
      end
      return res;
   endfunction

   task automatic note_mismatch(string what, word_type want, word_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch on %s: expected %08h, got %08h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin : monitor
      block_type got, want;
      int        w;
      if (reset) begin
         cipher_key = '0;
         expected_blocks.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite)
               cipher_key[csr_paddr[3:2]] = csr_pwdata;
            else if (csr_prdata !== cipher_key[csr_paddr[3:2]])
               note_mismatch($sformatf("key read at %0h", csr_paddr), cipher_key[csr_paddr[3:2]],
                             csr_prdata);
         end
         if (req_valid && req_ready)
            expected_blocks.push_back(xtea2_transform(req_type,
               {req_block_word3, req_block_word2, req_block_word1, req_block_word0}, cipher_key));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_word3, rsp_out_word2, rsp_out_word1, rsp_out_word0};
            if (expected_blocks.size() == 0) begin
               note_mismatch("unexpected result beat, word0", '0, got[0]);
            end else begin
               want = expected_blocks.pop_front();
               blocks_checked++;
               for (w = 0; w < 4; w++)
                  if (got[w] !== want[w])
                     note_mismatch($sformatf("out_word%0d of result %0d", w, blocks_checked),
                                   want[w], got[w]);
            end
         end
      end
      blocks_pending = expected_blocks.size();
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// top of the xtea2_block_cipher testbench: clock, reset, key register writes and block stimulus
// depends on xt2_pkg, the block itself and xtea2_checker
module testbench
   import xt2_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int PIPE_DRAIN  = XT2_ROUNDS + 8;
   localparam int PHASES      = 6;
   localparam int PHASE_BLKS  = 135;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_type;
   logic [31:0]           req_block_word0, req_block_word1, req_block_word2, req_block_word3;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [31:0]           rsp_out_word0, rsp_out_word1, rsp_out_word2, rsp_out_word3;
   logic                  csr_psel, csr_penable, csr_pwrite;
   logic [XT2_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int mismatches, blocks_pending, blocks_checked;
   int cycles = 0;
   int enciphered = 0, deciphered = 0, key_settings = 1;
   bit no_idle = 0;

   xtea2_block_cipher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_block_word0(req_block_word0), .req_block_word1(req_block_word1),
      .req_block_word2(req_block_word2), .req_block_word3(req_block_word3),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_word0(rsp_out_word0), .rsp_out_word1(rsp_out_word1),
      .rsp_out_word2(rsp_out_word2), .rsp_out_word3(rsp_out_word3),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   xtea2_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_block_word0(req_block_word0), .req_block_word1(req_block_word1),
      .req_block_word2(req_block_word2), .req_block_word3(req_block_word3),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_word0(rsp_out_word0), .rsp_out_word1(rsp_out_word1),
      .rsp_out_word2(rsp_out_word2), .rsp_out_word3(rsp_out_word3),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .mismatches(mismatches), .blocks_pending(blocks_pending),
      .blocks_checked(blocks_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles with %0d results outstanding", cycles,
                  blocks_pending);
         $display("FAIL");
         $finish;
      end
   end

   function automatic int idle_gap();
      return no_idle ? 0 : $urandom_range(0, 15);
   endfunction

   // mostly full-range words, with extremes and small values mixed in
   function automatic word_type pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return word_type'($urandom_range(0, 63));
         3:       return {$urandom} & 32'hFFFF_FFE0;
         default: return $urandom;
      endcase
   endfunction

   // entered and left at a falling edge; valid stays up across back-to-back beats
   task automatic send_block(logic decipher, word_type w0, word_type w1, word_type w2,
                             word_type w3);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= decipher;
      req_block_word0 <= w0;
      req_block_word1 <= w1;
      req_block_word2 <= w2;
      req_block_word3 <= w3;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      if (decipher) deciphered++;
      else enciphered++;
   endtask

   // psel drops and the bus idles after each access before the next setup
   task automatic csr_access(logic wr, reg_idx_type idx, word_type val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (blocks_pending != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
   endtask

   // result side: random stall before each beat
   initial begin : drain
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = idle_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   initial begin : stimulus
      word_type patterns[8];
      word_type keys[4];
      int       p, i, n, dir;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = 1'b0;
      req_block_word0 = '0;
      req_block_word1 = '0;
      req_block_word2 = '0;
      req_block_word3 = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'h8000_0000, 32'h0000_0001, 32'h0000_001F, 32'hFFFF_FFE0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset keys: flat patterns both ways, then rotate-by-zero and rotate-by-31 first rounds
      no_idle = 1'b1;
      for (dir = 0; dir < 2; dir++)
         for (i = 0; i < 8; i++)
            send_block(dir[0], patterns[i], patterns[i], patterns[i], patterns[i]);
      no_idle = 1'b0;
      for (dir = 0; dir < 2; dir++) begin
         send_block(dir[0], 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
         send_block(dir[0], 32'hDEAD_BEEF, 32'h1234_5660, 32'hCAFE_F00D, 32'h8765_433F);
      end
      wait_idle();

      for (p = 0; p < PHASES; p++) begin
         for (i = 0; i < 4; i++) begin
            case (p)
               0:       keys[i] = '1;
               1:       keys[i] = patterns[4 + i];
               PHASES - 1: keys[i] = '0;
               default: keys[i] = $urandom;
            endcase
            csr_access(1'b1, reg_idx_type'(i), keys[i]);
         end
         for (i = 0; i < 4; i++)
            csr_access(1'b0, reg_idx_type'(i), '0);
         key_settings++;
         for (n = 0; n < PHASE_BLKS; n++) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
            send_block(1'($urandom_range(0, 1)), pick_word(), pick_word(), pick_word(),
                       pick_word());
         end
         wait_idle();
      end

      $display("%0d blocks sent (%0d enciphered, %0d deciphered) under %0d key settings",
               enciphered + deciphered, enciphered, deciphered, key_settings);
      $display("%0d result beats compared, %0d mismatches", blocks_checked, mismatches);
      if (mismatches == 0 && blocks_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
